// File: rtl/fbp_pkg.sv
// Package for the flux bit cell PLL: widths, reset values, divisors and FSM types.
package fbp_pkg;

   localparam int FRAC_BITS_DEF = 8;
   localparam int PERIOD_W      = 12;
   localparam int INTERVAL_W    = 16;
   localparam int RUN_W         = 16;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 12'd144;

   // Register index, taken from byte address bit 2.
   localparam logic REG_CELL_PERIOD = 1'b0;

   // Runs of this many zeros or fewer steer the clock by the phase error.
   localparam int SMALL_RUN = 3;

   // Reduced constant divisors: 40/100 = 2/5, 5/100 = 1/20, 10/100 = 1/10.
   localparam int RES_MUL = 2;
   localparam int RES_DIV = 5;
   localparam int ADJ_DIV = 20;
   localparam int LIM_DIV = 10;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_CHECK = 5'b00010,
      ST_DIV   = 5'b00100,
      ST_POST  = 5'b01000,
      ST_FIN   = 5'b10000
   } fsm_state_type;

   typedef enum logic [3:0] {
      OP_RUN = 4'b0001,
      OP_RES = 4'b0010,
      OP_ADJ = 4'b0100,
      OP_LIM = 4'b1000
   } div_op_type;

endpackage

// File: rtl/flux_bitcell_pll.sv
// Top level of the flux bit cell PLL data separator.
//
// Usage:
//   The req channel carries one flux interval (sample ticks between two
//   transitions) per item. The rsp channel returns at most one item per
//   request: the count of zero cells before the next one cell, saturated at
//   65535 with a flag. Short intervals (phase below half a cell) return nothing.
//   The csr port holds cell_period at byte address 0; writing it re-centres
//   the loop (clock to nominal, phase residual cleared). Write it only idle.
// Sequencing:
//   req_ready is high only while the sequencer is idle. A short interval steps
//   through accept and compare. An emitting interval steps through accept,
//   compare, a restoring divider for the run length over DW = FRAC_BITS+18
//   quotient bits (26 at the default), four post steps (clamp limit, residual,
//   clock step, clamp), the first three on one shared reciprocal multiplier,
//   and a result step, which sets the registered rsp_valid once the result register is free.
// Reset: synchronous, active high. Clears the sequencer and output valid, sets
//   cell_period to 144, the clock to its centre and the residual to zero.
// Stall: the result register holds the item while rsp_ready is low; the next
//   interval is accepted meanwhile, and a second result waits until it frees.
module flux_bitcell_pll #(
   parameter int FRAC_BITS = fbp_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // interval input
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [fbp_pkg::INTERVAL_W-1:0]    req_interval,
   // run result output
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [fbp_pkg::RUN_W-1:0]         rsp_zero_run,
   output logic                              rsp_run_saturated,
   // configuration port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [fbp_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [fbp_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [fbp_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   localparam int PW   = fbp_pkg::PERIOD_W;
   localparam int IW   = fbp_pkg::INTERVAL_W;
   localparam int ZW   = fbp_pkg::RUN_W;
   localparam int CW   = PW + FRAC_BITS + 1;   // cell clock, unsigned
   localparam int TW   = IW + FRAC_BITS + 2;   // phase sum, signed
   localparam int RW   = CW + 1;               // post-run remainder, signed
   localparam int NW   = CW + 2;               // clock before clamping, signed
   localparam int DW   = TW;                   // divider dividend / quotient
   localparam int CNTW = $clog2(DW);
   localparam int MW   = CW;                   // multiplier operand, magnitudes
   // Enough reciprocal fraction bits for exact quotients by divisors up to 32.
   localparam int RSH  = MW + 5;

   localparam logic [CW-1:0] CLOCK_RESET = CW'(fbp_pkg::PERIOD_RESET) << FRAC_BITS;

   // Rounded-up reciprocals of the constant divisors.
   localparam logic [MW+2:0] RCP_RES =
      (MW+3)'(((longint'(1) << RSH) + longint'(fbp_pkg::RES_DIV - 1))
              / longint'(fbp_pkg::RES_DIV));
   localparam logic [MW+2:0] RCP_ADJ =
      (MW+3)'(((longint'(1) << RSH) + longint'(fbp_pkg::ADJ_DIV - 1))
              / longint'(fbp_pkg::ADJ_DIV));
   localparam logic [MW+2:0] RCP_LIM =
      (MW+3)'(((longint'(1) << RSH) + longint'(fbp_pkg::LIM_DIV - 1))
              / longint'(fbp_pkg::LIM_DIV));

   // Centre clock of a period; a zero period counts as one.
   function automatic logic [CW-1:0] centre_f(input logic [PW-1:0] per);
      logic [PW-1:0] p1;
      p1 = (per == '0) ? PW'(1) : per;
      return {1'b0, p1, {FRAC_BITS{1'b0}}};
   endfunction

   fbp_pkg::fsm_state_type state_ff, state_in;
   fbp_pkg::div_op_type    op_ff, op_in;

   logic [PW-1:0]        period_ff, period_in;
   logic [CW-1:0]        clock_ff, clock_in;
   logic signed [TW-1:0] resid_ff, resid_in;
   logic signed [TW-1:0] ticks_ff, ticks_in;
   logic signed [RW-1:0] rem_ff, rem_in;
   logic signed [NW-1:0] nclk_ff, nclk_in;
   logic                 small_ff, small_in;
   logic                 neg_ff, neg_in;
   logic [CW-1:0]        part_ff, part_in;
   logic [DW-1:0]        quo_ff, quo_in;
   logic [CW-1:0]        dvs_ff, dvs_in;
   logic [CNTW-1:0]      cnt_ff, cnt_in;
   logic [MW-3:0]        lim_ff, lim_in;
   logic [ZW-1:0]        zrun_ff, zrun_in;
   logic                 zsat_ff, zsat_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ZW-1:0]        rsp_zero_run_ff, rsp_zero_run_in;
   logic                 rsp_run_saturated_ff, rsp_run_saturated_in;

   logic                 cfg_wr;
   logic [CW-1:0]        centre;
   logic signed [TW-1:0] half_t;
   logic signed [TW-1:0] above_half;
   logic [CW:0]          trial;
   logic [CW:0]          diff;
   logic signed [RW-1:0] rem_v;
   logic signed [NW-1:0] dbl_rem;
   logic [NW-1:0]        dbl_mag;
   logic signed [RW-1:0] adj_x;
   logic [RW-1:0]        adj_mag;
   logic [MW-1:0]        mul_a;
   logic [MW+2:0]        mul_b;
   logic [2*MW+2:0]      mul_p;
   logic [MW-3:0]        mul_q;
   logic signed [TW-1:0] res_q;
   logic signed [NW-1:0] delta;
   logic signed [NW-1:0] lim;
   logic signed [NW-1:0] cmin;
   logic signed [NW-1:0] cmax;
   logic                 run_sat;

   assign cfg_wr = csr_psel && csr_penable && csr_pwrite
                   && (csr_paddr[2] == fbp_pkg::REG_CELL_PERIOD);
   assign csr_pready = 1'b1;
   assign csr_prdata = {{(fbp_pkg::CSR_DATA_W-PW){1'b0}}, period_ff};

   assign centre = centre_f(period_ff);
   assign half_t = $signed({{(TW-CW+1){1'b0}}, clock_ff[CW-1:1]});
   assign above_half = ticks_ff - half_t;

   // One restoring divider step: shift in the next dividend bit, try subtract.
   assign trial = {part_ff, quo_ff[DW-1]};
   assign diff  = trial - {1'b0, dvs_ff};

   // Phase left after the last whole cell: remainder + half - clock.
   assign rem_v = $signed({1'b0, part_ff}) + $signed({2'b00, clock_ff[CW-1:1]})
                  - $signed({1'b0, clock_ff});
   assign dbl_rem = NW'(rem_v) * NW'(fbp_pkg::RES_MUL);
   assign dbl_mag = dbl_rem[NW-1] ? NW'(-dbl_rem) : NW'(dbl_rem);

   assign adj_x   = small_ff ? rem_ff
                             : $signed({1'b0, centre}) - $signed({1'b0, clock_ff});
   assign adj_mag = adj_x[RW-1] ? RW'(-adj_x) : RW'(adj_x);

   // Shared reciprocal multiplier: the run step scales the centre for the
   // clamp limit, later steps scale the magnitude held in quo.
   assign mul_a = (op_ff == fbp_pkg::OP_RUN) ? centre : quo_ff[MW-1:0];

   always_comb begin
      case (op_ff)
         fbp_pkg::OP_RUN: mul_b = RCP_LIM;
         fbp_pkg::OP_RES: mul_b = RCP_RES;
         default:         mul_b = RCP_ADJ;
      endcase
   end

   assign mul_p = {{(MW+3){1'b0}}, mul_a} * {{MW{1'b0}}, mul_b};
   assign mul_q = mul_p[2*MW+2:RSH];

   assign res_q = $signed({{(TW-MW+2){1'b0}}, mul_q});
   assign delta = neg_ff ? -$signed({{(NW-MW+2){1'b0}}, mul_q})
                         : $signed({{(NW-MW+2){1'b0}}, mul_q});
   assign lim   = $signed({{(NW-MW+2){1'b0}}, lim_ff});
   assign cmin  = $signed({2'b00, centre}) - lim;
   assign cmax  = $signed({2'b00, centre}) + lim;

   assign run_sat = |quo_ff[DW-1:ZW];

   assign req_ready         = (state_ff == fbp_pkg::ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_zero_run      = rsp_zero_run_ff;
   assign rsp_run_saturated = rsp_run_saturated_ff;

   always_comb begin
      state_in             = state_ff;
      op_in                = op_ff;
      period_in            = period_ff;
      clock_in             = clock_ff;
      resid_in             = resid_ff;
      ticks_in             = ticks_ff;
      rem_in               = rem_ff;
      nclk_in              = nclk_ff;
      small_in             = small_ff;
      neg_in               = neg_ff;
      part_in              = part_ff;
      quo_in               = quo_ff;
      dvs_in               = dvs_ff;
      cnt_in               = cnt_ff;
      lim_in               = lim_ff;
      zrun_in              = zrun_ff;
      zsat_in              = zsat_ff;
      rsp_zero_run_in      = rsp_zero_run_ff;
      rsp_run_saturated_in = rsp_run_saturated_ff;
      rsp_valid_in         = rsp_valid_ff && !rsp_ready;

      case (state_ff)
         fbp_pkg::ST_IDLE: begin
            if (cfg_wr) begin
               period_in = csr_pwdata[PW-1:0];
               clock_in  = centre_f(csr_pwdata[PW-1:0]);
               resid_in  = '0;
            end
            if (req_valid) begin
               ticks_in = resid_ff
                          + $signed({2'b00, req_interval, {FRAC_BITS{1'b0}}});
               state_in = fbp_pkg::ST_CHECK;
            end
         end
         fbp_pkg::ST_CHECK: begin
            if (ticks_ff < half_t) begin
               // Short interval: accumulate only.
               resid_in = ticks_ff;
               state_in = fbp_pkg::ST_IDLE;
            end else begin
               quo_in   = DW'(above_half);
               part_in  = '0;
               dvs_in   = clock_ff;
               neg_in   = 1'b0;
               cnt_in   = CNTW'(DW-1);
               op_in    = fbp_pkg::OP_RUN;
               state_in = fbp_pkg::ST_DIV;
            end
         end
         fbp_pkg::ST_DIV: begin
            if (!diff[CW]) begin
               part_in = diff[CW-1:0];
               quo_in  = {quo_ff[DW-2:0], 1'b1};
            end else begin
               part_in = trial[CW-1:0];
               quo_in  = {quo_ff[DW-2:0], 1'b0};
            end
            if (cnt_ff == '0) begin
               state_in = fbp_pkg::ST_POST;
            end else begin
               cnt_in = cnt_ff - CNTW'(1);
            end
         end
         fbp_pkg::ST_POST: begin
            // Advance one post step per cycle; the first three use the shared multiplier.
            case (op_ff)
               fbp_pkg::OP_RUN: begin
                  // Quotient is the zero count; take the clamp limit and set
                  // up the residual scaling.
                  zsat_in  = run_sat;
                  zrun_in  = run_sat ? '1 : quo_ff[ZW-1:0];
                  small_in = (quo_ff <= DW'(fbp_pkg::SMALL_RUN));
                  rem_in   = rem_v;
                  lim_in   = mul_q;
                  quo_in   = {{(DW-NW){1'b0}}, dbl_mag};
                  neg_in   = dbl_rem[NW-1];
                  op_in    = fbp_pkg::OP_RES;
               end
               fbp_pkg::OP_RES: begin
                  // Keep 40 percent of the phase, truncated toward zero.
                  resid_in = neg_ff ? -res_q : res_q;
                  quo_in   = {{(DW-RW){1'b0}}, adj_mag};
                  neg_in   = adj_x[RW-1];
                  op_in    = fbp_pkg::OP_ADJ;
               end
               fbp_pkg::OP_ADJ: begin
                  nclk_in = $signed({2'b00, clock_ff}) + delta;
                  op_in   = fbp_pkg::OP_LIM;
               end
               fbp_pkg::OP_LIM: begin
                  // Clamp to centre +/- 10 percent.
                  if (nclk_ff < cmin) begin
                     clock_in = cmin[CW-1:0];
                  end else if (nclk_ff > cmax) begin
                     clock_in = cmax[CW-1:0];
                  end else begin
                     clock_in = nclk_ff[CW-1:0];
                  end
                  state_in = fbp_pkg::ST_FIN;
               end
               default: begin
                  state_in = fbp_pkg::ST_IDLE;
               end
            endcase
         end
         fbp_pkg::ST_FIN: begin
            // Hold until the result register is free.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in         = 1'b1;
               rsp_zero_run_in      = zrun_ff;
               rsp_run_saturated_in = zsat_ff;
               state_in             = fbp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fbp_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fbp_pkg::ST_IDLE;
         op_ff        <= fbp_pkg::OP_RUN;
         period_ff    <= fbp_pkg::PERIOD_RESET;
         clock_ff     <= CLOCK_RESET;
         resid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         period_ff    <= period_in;
         clock_ff     <= clock_in;
         resid_ff     <= resid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ticks_ff             <= ticks_in;
      rem_ff               <= rem_in;
      nclk_ff              <= nclk_in;
      small_ff             <= small_in;
      neg_ff               <= neg_in;
      part_ff              <= part_in;
      quo_ff               <= quo_in;
      dvs_ff               <= dvs_in;
      cnt_ff               <= cnt_in;
      lim_ff               <= lim_in;
      zrun_ff              <= zrun_in;
      zsat_ff              <= zsat_in;
      rsp_zero_run_ff      <= rsp_zero_run_in;
      rsp_run_saturated_ff <= rsp_run_saturated_in;
   end

endmodule
